/* src/clnw_pkg.sv */
// Shared types and constants for the character LCD number writer.
// No dependencies; every other file imports this package.
`default_nettype none

package clnw_pkg;

    localparam int MAX_FIELD_LEN = 16;
    localparam int MAX_COLUMNS   = 40;
    localparam int HEX_MAX_LEN   = 4;
    localparam int DEC_DIGITS    = 5;
    localparam int BIN_W         = 16;
    localparam int BCD_W         = 4 * DEC_DIGITS;
    localparam int CNT_W         = $clog2(MAX_FIELD_LEN + 1);
    localparam int POS_W         = $clog2(MAX_FIELD_LEN);
    localparam int STEP_W        = $clog2(BIN_W);

    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [6:0] ROW2_OFFSET  = 7'h40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_ONE    = 8'h31;
    localparam logic [7:0] ASCII_A      = 8'h41;
    localparam logic [7:0] ASCII_PLUS   = 8'h2B;
    localparam logic [7:0] ASCII_MINUS  = 8'h2D;
    localparam logic [7:0] ROW_FIRST    = 8'd1;
    localparam logic [7:0] ROW_SECOND   = 8'd2;

    typedef enum logic [2:0] {
        KIND_UDEC = 3'd0,
        KIND_SDEC = 3'd1,
        KIND_HEX  = 3'd2,
        KIND_BIN  = 3'd3,
        KIND_CHAR = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic             start;
        logic [BIN_W-1:0] bin;
    } clnw_bcd_req_t;

    typedef struct packed {
        logic             busy;
        logic [BCD_W-1:0] digits;
    } clnw_bcd_rsp_t;

endpackage

`default_nettype wire

/* src/clnw_req_if.sv */
// Request channel: one display request per item.
// Depends on clnw_pkg.
`default_nettype none

interface clnw_req_if
    import clnw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [2:0]       kind;
    logic [7:0]       row;
    logic [7:0]       column;
    logic [BIN_W-1:0] value;
    logic [7:0]       length;

    modport source (output valid, kind, row, column, value, length, input ready);
    modport sink   (input valid, kind, row, column, value, length, output ready);
endinterface

`default_nettype wire

/* src/clnw_wr_if.sv */
// Write channel: one LCD bus write per item.
// Depends on clnw_pkg (imported for consistency).
`default_nettype none

interface clnw_wr_if
    import clnw_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;

    modport source (output valid, is_data, bus_byte, last, input ready);
    modport sink   (input valid, is_data, bus_byte, last, output ready);
endinterface

`default_nettype wire

/* src/clnw_bcd.sv */
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on clnw_pkg.
`default_nettype none

module clnw_bcd
    import clnw_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire clnw_bcd_req_t req,
    output clnw_bcd_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [BIN_W-1:0]  sh_reg, sh_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adj;

    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                        : bcd_reg[i*4 +: 4];
        end

        busy_next = busy_reg;
        step_next = step_reg;
        sh_next   = sh_reg;
        bcd_next  = bcd_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            sh_next   = req.bin;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], sh_reg[BIN_W-1]};
            sh_next   = {sh_reg[BIN_W-2:0], 1'b0};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(BIN_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.digits = bcd_reg;

endmodule

`default_nettype wire

/* src/clnw_seq.sv */
// Request sequencer: checks a request, emits the cursor command and then one
// character per write through an output register. Depends on clnw_pkg and
// the channel interfaces; takes decimal digits from clnw_bcd.
`default_nettype none

module clnw_seq
    import clnw_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    clnw_req_if.sink           req,
    clnw_wr_if.source          wr,
    output clnw_bcd_req_t      bcd_req,
    input  wire clnw_bcd_rsp_t bcd_rsp
);

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [BIN_W-1:0] value_reg, value_next;
    logic [6:0]       addr_reg, addr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sign_reg, sign_next;

    logic             out_valid_reg, out_valid_next;
    logic             is_data_reg, is_data_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;

    // request decode
    kind_t            in_kind;
    logic             row_ok, col_ok, len_ok, req_ok;
    logic [CNT_W-1:0] len_sat, dlen;
    logic [6:0]       in_addr;

    // data path for the current write
    logic [POS_W-1:0] pos;
    logic [3:0]       dec_digit, hex_digit;
    logic             is_dec, need_bcd, stall, can_load, data_last;
    logic [7:0]       data_byte;

    assign in_kind = kind_t'(req.kind);
    assign row_ok  = (req.row == ROW_FIRST) || (req.row == ROW_SECOND);
    assign col_ok  = (req.column >= 8'd1) && (req.column <= 8'(MAX_COLUMNS));
    assign len_sat = (req.length > 8'(MAX_FIELD_LEN)) ? CNT_W'(MAX_FIELD_LEN)
                                                      : req.length[CNT_W-1:0];
    assign in_addr = 7'(req.column - 8'd1) + ((req.row == ROW_SECOND) ? ROW2_OFFSET : 7'd0);

    always_comb
    begin
        unique case (in_kind)
            KIND_UDEC, KIND_HEX, KIND_BIN: len_ok = (req.length >= 8'd1);
            KIND_SDEC:                     len_ok = (req.length >= 8'd2);
            KIND_CHAR:                     len_ok = 1'b1;
            default:                       len_ok = 1'b0;
        endcase

        unique case (in_kind)
            KIND_UDEC, KIND_BIN: dlen = len_sat;
            KIND_SDEC:           dlen = len_sat - 1'b1;
            KIND_HEX:            dlen = (req.length > 8'(HEX_MAX_LEN)) ? CNT_W'(HEX_MAX_LEN)
                                                                       : req.length[CNT_W-1:0];
            KIND_CHAR:           dlen = CNT_W'(1);
            default:             dlen = '0;
        endcase
    end

    assign req_ok = row_ok && col_ok && len_ok;

    // position counts down from the digit count minus one to zero
    assign pos      = POS_W'(cnt_reg - 1'b1);
    assign is_dec   = (kind_reg == KIND_UDEC) || (kind_reg == KIND_SDEC);
    assign need_bcd = is_dec && !sign_reg && (pos < POS_W'(DEC_DIGITS));
    assign stall    = need_bcd && bcd_rsp.busy;
    assign can_load = !out_valid_reg || wr.ready;
    assign data_last = !sign_reg && (cnt_reg == CNT_W'(1));

    always_comb
    begin
        dec_digit = 4'd0;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (pos == POS_W'(i))
                dec_digit = bcd_rsp.digits[i*4 +: 4];
        end
        hex_digit = 4'(value_reg >> {pos[1:0], 2'b00});

        if (sign_reg)
            data_byte = value_reg[BIN_W-1] ? ASCII_MINUS : ASCII_PLUS;
        else
        begin
            unique case (kind_reg)
                KIND_UDEC, KIND_SDEC: data_byte = ASCII_ZERO | {4'd0, dec_digit};
                KIND_HEX:  data_byte = (hex_digit <= 4'd9) ? ASCII_ZERO + {4'd0, hex_digit}
                                                           : ASCII_A + {4'd0, hex_digit} - 8'd10;
                KIND_BIN:  data_byte = value_reg[pos] ? ASCII_ONE : ASCII_ZERO;
                KIND_CHAR: data_byte = value_reg[7:0];
                default:   data_byte = value_reg[7:0];
            endcase
        end
    end

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && !wr.ready;
        is_data_next   = is_data_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        bcd_req.start  = 1'b0;
        bcd_req.bin    = (in_kind == KIND_SDEC && req.value[BIN_W-1]) ?
                         BIN_W'(~req.value + 1'b1) : req.value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next     = in_kind;
                    value_next    = req.value;
                    addr_next     = in_addr;
                    cnt_next      = dlen;
                    sign_next     = (in_kind == KIND_SDEC);
                    bcd_req.start = 1'b1;
                    if (req_ok)
                        state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b0;
                    byte_next      = CMD_SET_ADDR | {1'b0, addr_reg};
                    last_next      = 1'b0;
                    state_next     = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (can_load && !stall)
                begin
                    out_valid_next = 1'b1;
                    is_data_next   = 1'b1;
                    byte_next      = data_byte;
                    last_next      = data_last;
                    if (sign_reg)
                        sign_next = 1'b0;
                    else
                        cnt_next = cnt_reg - 1'b1;
                    if (data_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        addr_reg    <= addr_next;
        cnt_reg     <= cnt_next;
        sign_reg    <= sign_next;
        is_data_reg <= is_data_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

    assign wr.valid    = out_valid_reg;
    assign wr.is_data  = is_data_reg;
    assign wr.bus_byte = byte_reg;
    assign wr.last     = last_reg;

endmodule

`default_nettype wire

/* src/char_lcd_number_writer_unit.sv */
// Character LCD number writer: turns one display request into LCD bus writes.
// Channels: req (sink) takes kind, row, column, value, length; wr (source)
// gives is_data, bus_byte, last, one write per item, valid/ready handshake.
// A valid request gives a cursor command (RS low), then 1 to 16 data writes;
// last marks the final write. An invalid request gives no writes.
// The command write is loaded into the output register from ST_CMD after the
// request item is taken in ST_IDLE; ST_CMD waits while the output is held.
// The sequencer puts one write per cycle into the output register while wr
// is ready and no BCD wait holds it. Decimal kinds wait for the bit-serial
// BCD converter (started when the request is taken) before the last five
// digit positions; padding zeros and the sign overlap the conversion.
// req.ready is high only while no request is in progress.
// Reset clears the sequencer and output valid; no writes are pending after.
// When the receiver stalls, the current write holds on wr and the sequencer
// waits; nothing is dropped.
`default_nettype none

module char_lcd_number_writer_unit
    import clnw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    clnw_req_if.sink  req,
    clnw_wr_if.source wr
);

    clnw_bcd_req_t bcd_req;
    clnw_bcd_rsp_t bcd_rsp;

    clnw_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (bcd_req),
        .rsp   (bcd_rsp)
    );

    clnw_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .wr      (wr),
        .bcd_req (bcd_req),
        .bcd_rsp (bcd_rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/char_lcd_number_writer_unit_test.sv */
// Self-checking test of the character LCD number writer: directed and random
// display requests, predicted LCD bus writes checked in order on the wr channel.
// Depends on clnw_pkg, clnw_req_if, clnw_wr_if and char_lcd_number_writer_unit.
`timescale 1ns / 100ps

module char_lcd_number_writer_unit_test;
    import clnw_pkg::*;

    localparam int unsigned RANDOM_REQUESTS = 190;
    localparam int unsigned LIMIT_CYCLES    = 900_000;
    localparam int unsigned DRAIN_CYCLES    = 40;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       row;
        logic [7:0]       column;
        logic [BIN_W-1:0] value;
        logic [7:0]       length;
    } lcd_request_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lcd_request_t requests_to_send [$];
    lcd_write_t   lcd_writes_due [$];

    lcd_request_t send_item  = '0;
    logic         send_valid = 1'b0;
    logic         take_ready = 1'b0;
    int unsigned  req_gap    = 0;
    int unsigned  req_calm   = 0;
    int unsigned  wr_stall   = 0;
    int unsigned  wr_calm    = 0;
    int unsigned  errors     = 0;
    int unsigned  cycle_count = 0;

    clnw_req_if req_ch();
    clnw_wr_if  wr_ch();

    assign req_ch.valid  = send_valid;
    assign req_ch.kind   = send_item.kind;
    assign req_ch.row    = send_item.row;
    assign req_ch.column = send_item.column;
    assign req_ch.value  = send_item.value;
    assign req_ch.length = send_item.length;
    assign wr_ch.ready   = take_ready;

    char_lcd_number_writer_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .wr    (wr_ch)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic void queue_data(input logic [7:0] ch);
        lcd_writes_due.push_back('{is_data: 1'b1, bus_byte: ch, last: 1'b0});
    endfunction

    function automatic void predict_lcd_writes(input lcd_request_t rq);
        int unsigned len;
        int unsigned mag;
        int unsigned k;
        int unsigned digits [DEC_DIGITS];
        logic [3:0]  nib;
        logic [6:0]  addr;
        lcd_write_t  w;
        if (!(rq.row == ROW_FIRST || rq.row == ROW_SECOND)) return;
        if (rq.column < 8'd1 || rq.column > MAX_COLUMNS) return;
        if (rq.kind > KIND_CHAR) return;
        if (rq.kind == KIND_SDEC)
        begin
            if (rq.length < 8'd2) return;
        end
        else if (rq.kind != KIND_CHAR && rq.length < 8'd1)
        begin
            return;
        end

        addr = 7'(rq.column - 8'd1);
        if (rq.row == ROW_SECOND) addr = addr + ROW2_OFFSET;
        lcd_writes_due.push_back('{is_data: 1'b0, bus_byte: CMD_SET_ADDR | {1'b0, addr},
                                   last: 1'b0});

        len = rq.length;
        case (kind_t'(rq.kind))
            KIND_UDEC, KIND_SDEC:
            begin
                if (len > MAX_FIELD_LEN) len = MAX_FIELD_LEN;
                mag = rq.value;
                if (rq.kind == KIND_SDEC)
                begin
                    len = len - 1;
                    if (rq.value[BIN_W-1])
                    begin
                        queue_data(ASCII_MINUS);
                        mag = 32'h10000 - rq.value;
                    end
                    else
                    begin
                        queue_data(ASCII_PLUS);
                    end
                end
                for (k = len; k > DEC_DIGITS; k--) queue_data(ASCII_ZERO);
                if (len > DEC_DIGITS) len = DEC_DIGITS;
                for (k = 0; k < DEC_DIGITS; k++)
                begin
                    digits[k] = mag % 10;
                    mag = mag / 10;
                end
                for (k = len; k > 0; k--) queue_data(ASCII_ZERO | 8'(digits[k-1]));
            end
            KIND_HEX:
            begin
                if (len > HEX_MAX_LEN) len = HEX_MAX_LEN;
                for (k = len; k > 0; k--)
                begin
                    nib = rq.value[4*(k-1) +: 4];
                    queue_data(nib <= 4'd9 ? ASCII_ZERO + nib : ASCII_A + nib - 8'd10);
                end
            end
            KIND_BIN:
            begin
                if (len > MAX_FIELD_LEN) len = MAX_FIELD_LEN;
                for (k = len; k > 0; k--) queue_data(rq.value[k-1] ? ASCII_ONE : ASCII_ZERO);
            end
            default:
            begin
                queue_data(rq.value[7:0]);
            end
        endcase

        w = lcd_writes_due.pop_back();
        w.last = 1'b1;
        lcd_writes_due.push_back(w);
    endfunction

    function automatic void add_request(input logic [2:0] kind, input logic [7:0] row,
                                        input logic [7:0] column,
                                        input logic [BIN_W-1:0] value,
                                        input logic [7:0] length);
        requests_to_send.push_back('{kind: kind, row: row, column: column, value: value,
                                     length: length});
    endfunction

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_item  <= '0;
            req_gap    <= 0;
        end
        else
        begin
            if (send_valid && req_ch.ready) predict_lcd_writes(send_item);
            if (send_valid && !req_ch.ready)
            begin
                // hold the item until taken
            end
            else if (req_gap != 0)
            begin
                req_gap    <= req_gap - 1;
                send_valid <= 1'b0;
            end
            else if (requests_to_send.size() != 0)
            begin
                send_item  <= requests_to_send.pop_front();
                send_valid <= 1'b1;
                req_gap    <= pick_gap(req_calm);
            end
            else
            begin
                send_valid <= 1'b0;
            end
        end
    end

    // Write monitor with random back-pressure
    always @(posedge clk)
    begin
        lcd_write_t got;
        lcd_write_t want;
        int unsigned g;
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            wr_stall   <= 0;
        end
        else if (wr_ch.valid && take_ready)
        begin
            got = '{is_data: wr_ch.is_data, bus_byte: wr_ch.bus_byte, last: wr_ch.last};
            if (lcd_writes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected write is_data=%b bus_byte=%h last=%b",
                         $time, got.is_data, got.bus_byte, got.last);
            end
            else
            begin
                want = lcd_writes_due.pop_front();
                if (got.is_data !== want.is_data || got.bus_byte !== want.bus_byte ||
                    got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: write mismatch expected is_data=%b bus_byte=%h last=%b, got is_data=%b bus_byte=%h last=%b",
                             $time, want.is_data, want.bus_byte, want.last,
                             got.is_data, got.bus_byte, got.last);
                end
            end
            g = pick_gap(wr_calm);
            if (g != 0)
            begin
                take_ready <= 1'b0;
                wr_stall   <= g - 1;
            end
            else
            begin
                take_ready <= 1'b1;
            end
        end
        else if (wr_stall != 0)
        begin
            wr_stall   <= wr_stall - 1;
            take_ready <= 1'b0;
        end
        else
        begin
            take_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[char_lcd_number_writer_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned r;
        logic [2:0]       kind;
        logic [BIN_W-1:0] value;
        logic [7:0]       len;

        // Directed: field extremes, clamping, padding, sign edges, rejects
        add_request(KIND_UDEC, ROW_FIRST,  8'd1,  16'd0,     8'd1);
        add_request(KIND_UDEC, ROW_SECOND, 8'd40, 16'hFFFF,  8'd5);
        add_request(KIND_UDEC, ROW_FIRST,  8'd20, 16'd12345, 8'd16);
        add_request(KIND_UDEC, ROW_SECOND, 8'd7,  16'hFFFF,  8'd255);
        add_request(KIND_UDEC, ROW_FIRST,  8'd3,  16'hFFFF,  8'd3);
        add_request(KIND_UDEC, ROW_FIRST,  8'd1,  16'd5,     8'd0);
        add_request(KIND_SDEC, ROW_FIRST,  8'd1,  16'h7FFF,  8'd6);
        add_request(KIND_SDEC, ROW_SECOND, 8'd40, 16'h8000,  8'd6);
        add_request(KIND_SDEC, ROW_FIRST,  8'd2,  16'hFFFF,  8'd2);
        add_request(KIND_SDEC, ROW_FIRST,  8'd2,  16'd1,     8'd1);
        add_request(KIND_SDEC, ROW_SECOND, 8'd9,  16'h8001,  8'd200);
        add_request(KIND_HEX,  ROW_FIRST,  8'd1,  16'hABCD,  8'd4);
        add_request(KIND_HEX,  ROW_SECOND, 8'd40, 16'h1234,  8'd255);
        add_request(KIND_HEX,  ROW_FIRST,  8'd5,  16'h00F9,  8'd1);
        add_request(KIND_HEX,  ROW_FIRST,  8'd5,  16'hFFFF,  8'd0);
        add_request(KIND_BIN,  ROW_FIRST,  8'd1,  16'h8001,  8'd16);
        add_request(KIND_BIN,  ROW_SECOND, 8'd30, 16'hAAAA,  8'd255);
        add_request(KIND_BIN,  ROW_FIRST,  8'd30, 16'd1,     8'd0);
        add_request(KIND_CHAR, ROW_FIRST,  8'd1,  16'hFF41,  8'd0);
        add_request(KIND_CHAR, ROW_SECOND, 8'd40, 16'h0000,  8'd255);
        for (int u = int'(KIND_CHAR) + 1; u < 8; u++)
            add_request(3'(u), ROW_FIRST, 8'd1, 16'h1234, 8'd4);
        add_request(KIND_UDEC, 8'd0,       8'd1,   16'd42,   8'd3);
        add_request(KIND_HEX,  8'd3,       8'd255, 16'hBEEF, 8'd4);
        add_request(KIND_BIN,  8'd255,     8'd10,  16'hFFFF, 8'd8);
        add_request(KIND_UDEC, ROW_FIRST,  8'd0,   16'd42,   8'd3);
        add_request(KIND_CHAR, ROW_SECOND, 8'd41,  16'h0041, 8'd1);

        // Random: well-formed requests with random content, noise in between
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                if ($urandom_range(0, 1) != 0)
                    add_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 16'($urandom),
                                8'($urandom_range(0, 255)));
                else
                    add_request(3'($urandom_range(0, 7)), 8'($urandom_range(1, 2)),
                                8'($urandom_range(0, 41)), 16'($urandom),
                                8'($urandom_range(0, 1)));
            end
            kind = 3'($urandom_range(0, int'(KIND_CHAR)));
            r = $urandom_range(0, 9);
            if (r == 0)      value = '0;
            else if (r == 1) value = '1;
            else if (r == 2) value = $urandom_range(0, 1) != 0 ? 16'h8000 : 16'h7FFF;
            else             value = 16'($urandom);
            r = $urandom_range(0, 9);
            if (r < 6)      len = 8'($urandom_range(1, 8));
            else if (r < 9) len = 8'($urandom_range(9, 17));
            else            len = 8'($urandom_range(18, 255));
            if (kind == KIND_SDEC && len < 8'd2) len = 8'd2;
            add_request(kind, 8'($urandom_range(1, 2)), 8'($urandom_range(1, MAX_COLUMNS)),
                        value, len);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_to_send.size() != 0 || send_valid) @(posedge clk);
        while (lcd_writes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && lcd_writes_due.size() == 0)
            $display("[char_lcd_number_writer_unit] OK");
        else
            $display("[char_lcd_number_writer_unit] ERROR");
        $finish;
    end

endmodule
